>>> hdl/bcms_pkg.sv
// Shared types, constants and code tables for the CAN message segmenter.
`timescale 1ns / 1ps

package bcms_pkg;

    // Segment class codes carried on the input word
    typedef enum logic [1:0] {
        SEG_CLASS_9X = 2'd0,
        SEG_CLASS_AX = 2'd1,
        SEG_CLASS_8X = 2'd2
    } t_seg_class;

    localparam int          FRAME_BYTES    = 8;
    localparam logic [3:0]  FRAME_FULL     = 4'd8;
    localparam logic [7:0]  MAX_UNSEG_LEN  = 8'd6;
    localparam logic [2:0]  MARKER_SPAN    = 3'd7;
    localparam logic [2:0]  HEADER_SPAN    = 3'd3;
    localparam logic [3:0]  HEADER_BYTES   = 4'd4;
    localparam logic [3:0]  UNSEG_HDR      = 4'd2;

    // Classified input word, as queued between front and back end
    typedef struct packed {
        logic [7:0] payload;
        logic       byte_valid;
        logic       first;
        logic       last;
        logic       seg;
        logic       too_long;
        logic [7:0] msg_len;
        logic [7:0] func_idx;
        logic [7:0] func_type;
        logic [7:0] start_code;
        logic [7:0] cont_code;
    } t_op;

    // One outgoing frame
    typedef struct packed {
        logic [3:0]                       length;
        logic [FRAME_BYTES-1:0][7:0]      bytes;
        logic                             last;
    } t_frame;

    // Start code of a segmented message
    function automatic logic [7:0] start_code(input logic [1:0] cls);
        logic [7:0] code;
        unique case (cls)
            SEG_CLASS_9X: code = 8'h90;
            SEG_CLASS_AX: code = 8'hA0;
            SEG_CLASS_8X: code = 8'h80;
            default:      code = 8'h80;
        endcase
        return code;
    endfunction

    // Continuation code base (low nibble carries the sequence count)
    function automatic logic [7:0] cont_code(input logic [1:0] cls);
        logic [7:0] code;
        unique case (cls)
            SEG_CLASS_9X: code = 8'hD0;
            SEG_CLASS_AX: code = 8'hE0;
            SEG_CLASS_8X: code = 8'hC0;
            default:      code = 8'hC0;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/bcms_front.sv
// Front end: accepts input words and decodes class codes and the drop condition.
`timescale 1ns / 1ps

module bcms_front
    import bcms_pkg::*;
(
    input  logic       i_valid,
    input  logic       i_q_full,
    input  logic [7:0] i_payload_byte,
    input  logic       i_byte_valid,
    input  logic       i_first_item,
    input  logic       i_last_item,
    input  logic [7:0] i_message_length,
    input  logic [7:0] i_function_index,
    input  logic [7:0] i_function_type,
    input  logic [1:0] i_segment_class,
    input  logic       i_segmented,
    output logic       o_ready,
    output logic       o_push,
    output t_op        o_op
);

    // Handshake: take a word whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Classification
    always_comb begin
        o_op.payload    = i_payload_byte;
        o_op.byte_valid = i_byte_valid;
        o_op.first      = i_first_item;
        o_op.last       = i_last_item;
        o_op.seg        = i_segmented;
        o_op.too_long   = i_message_length > MAX_UNSEG_LEN;
        o_op.msg_len    = i_message_length;
        o_op.func_idx   = i_function_index;
        o_op.func_type  = i_function_type;
        o_op.start_code = start_code(i_segment_class);
        o_op.cont_code  = cont_code(i_segment_class);
    end

endmodule

>>> hdl/bcms_fifo.sv
// Short queue of classified words between front and back end.
`timescale 1ns / 1ps

module bcms_fifo
    import bcms_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

>>> hdl/bcms_back.sv
// Back end: frame packing state, continuation insertion and frame output register.
`timescale 1ns / 1ps

module bcms_back
    import bcms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_op    i_op,
    input  logic   i_op_valid,
    output logic   o_op_pop,
    output t_frame o_frame,
    output logic   o_frame_valid,
    input  logic   i_frame_ready
);

    // Packing state
    logic [7:0] r_buf [FRAME_BYTES];
    logic [3:0] r_fill;
    logic [2:0] r_bsm;
    logic [3:0] r_seq;
    logic [7:0] r_cc;
    logic       r_drop;

    // Output register
    logic       r_out_valid;
    t_frame     r_out;
    t_frame     n_out;

    // Working values for one word
    logic [7:0] v_buf  [FRAME_BYTES];
    logic [7:0] v_frm  [FRAME_BYTES];
    logic [7:0] v_push [2];
    logic [1:0] v_push_en;
    logic [3:0] v_fill;
    logic [2:0] v_bsm;
    logic [3:0] v_seq;
    logic [7:0] v_cc;
    logic       v_drop;
    logic       v_emit;
    logic [3:0] v_flen;
    logic       v_flast;
    logic       w_step;

    // One word per cycle while the output register can take a frame
    assign w_step        = i_op_valid && (!r_out_valid || i_frame_ready);
    assign o_op_pop      = w_step;
    assign o_frame       = r_out;
    assign o_frame_valid = r_out_valid;

    // Effect of one word on the packing state
    always_comb begin
        v_buf     = r_buf;
        v_frm     = r_buf;
        v_fill    = r_fill;
        v_bsm     = r_bsm;
        v_seq     = r_seq;
        v_cc      = r_cc;
        v_drop    = r_drop;
        v_emit    = 1'b0;
        v_flen    = FRAME_FULL;
        v_flast   = 1'b0;
        v_push[0] = i_op.payload;
        v_push[1] = i_op.payload;
        v_push_en = 2'b00;

        // Start of message
        if (i_op.first) begin
            v_fill = '0;
            v_bsm  = '0;
            v_seq  = '0;
            v_drop = 1'b0;
            if (i_op.seg) begin
                v_cc     = i_op.cont_code;
                v_buf[0] = i_op.start_code;
                v_buf[1] = i_op.msg_len;
                v_buf[2] = i_op.func_idx;
                v_buf[3] = i_op.func_type;
                v_fill   = HEADER_BYTES;
                v_bsm    = HEADER_SPAN;
            end else if (i_op.too_long) begin
                v_drop = 1'b1;
            end else begin
                v_buf[0] = i_op.func_idx;
                v_buf[1] = i_op.func_type;
                v_fill   = UNSEG_HDR;
            end
        end

        // Payload byte; segmented: a continuation byte opens each later frame
        if (!v_drop && i_op.byte_valid) begin
            if (i_op.seg) begin
                if (v_bsm == MARKER_SPAN) begin
                    v_push[0] = v_cc | {4'h0, v_seq};
                    v_push_en = 2'b11;
                    v_seq     = v_seq + 4'd1;
                    v_bsm     = '0;
                end else begin
                    v_push_en = 2'b01;
                end
                v_bsm = v_bsm + 3'd1;
                for (int k = 0; k < 2; k++) begin
                    if (v_push_en[k]) begin
                        if (v_fill >= FRAME_FULL) begin
                            v_fill = '0;
                        end
                        v_buf[v_fill[2:0]] = v_push[k];
                        v_fill = v_fill + 4'd1;
                        if (v_fill == FRAME_FULL) begin
                            v_emit = 1'b1;
                            v_frm  = v_buf;
                            v_flen = FRAME_FULL;
                            v_fill = '0;
                        end
                    end
                end
            end else if (v_fill < FRAME_FULL) begin
                v_buf[v_fill[2:0]] = i_op.payload;
                v_fill = v_fill + 4'd1;
            end
        end

        // End of message: mark or flush
        if (i_op.last) begin
            if (v_drop) begin
                v_drop = 1'b0;
            end else if (i_op.seg) begin
                if (v_emit) begin
                    v_flast = 1'b1;
                end else if (v_fill != '0) begin
                    v_emit  = 1'b1;
                    v_frm   = v_buf;
                    v_flen  = v_fill;
                    v_flast = 1'b1;
                end
                v_fill = '0;
            end else if (v_fill != '0) begin
                v_emit  = 1'b1;
                v_frm   = v_buf;
                v_flen  = v_fill;
                v_flast = 1'b1;
                v_fill  = '0;
            end
        end

        // Frame word, unused bytes zeroed
        n_out.length = v_flen;
        n_out.last   = v_flast;
        for (int j = 0; j < FRAME_BYTES; j++) begin
            n_out.bytes[j] = (4'(j) < v_flen) ? v_frm[j] : 8'h00;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_bsm       <= '0;
            r_seq       <= '0;
            r_cc        <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_fill <= v_fill;
                r_bsm  <= v_bsm;
                r_seq  <= v_seq;
                r_cc   <= v_cc;
                r_drop <= v_drop;
            end
            if (w_step && v_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_frame_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame buffer and output data
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_buf <= v_buf;
        end
        if (w_step && v_emit) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/bap_can_message_segmenter_top.sv
// Top level of the CAN message segmenter: front end, word queue and frame packer.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   payload byte, flags, length, index, type, class
//  frames    out        o_valid / i_ready   frame length, eight frame bytes, last flag
//
// Sustained rate is one input word per cycle while the frame output is not stalled; each word yields at most one frame.
// A frame reaches the outputs by way of the queue write when its word is accepted
// and then the packer step into the output register.
// The packer steps only when the output register is empty or being drained, so
// output stalls back up through the queue to o_ready.
// Reset is synchronous and active low; no clearing pass is needed after it.
`timescale 1ns / 1ps

module bap_can_message_segmenter_top
    import bcms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_payload_byte,
    input  logic       i_byte_valid,
    input  logic       i_first_item,
    input  logic       i_last_item,
    input  logic [7:0] i_message_length,
    input  logic [7:0] i_function_index,
    input  logic [7:0] i_function_type,
    input  logic [1:0] i_segment_class,
    input  logic       i_segmented,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_frame_length,
    output logic [7:0] o_frame_byte0,
    output logic [7:0] o_frame_byte1,
    output logic [7:0] o_frame_byte2,
    output logic [7:0] o_frame_byte3,
    output logic [7:0] o_frame_byte4,
    output logic [7:0] o_frame_byte5,
    output logic [7:0] o_frame_byte6,
    output logic [7:0] o_frame_byte7,
    output logic       o_last_frame
);

    t_op    w_in_op;
    t_op    w_q_op;
    t_frame w_frame;
    logic   w_push;
    logic   w_pop;
    logic   w_q_full;
    logic   w_q_empty;

    // Front end
    bcms_front u_front (
        .i_valid          (i_valid),
        .i_q_full         (w_q_full),
        .i_payload_byte   (i_payload_byte),
        .i_byte_valid     (i_byte_valid),
        .i_first_item     (i_first_item),
        .i_last_item      (i_last_item),
        .i_message_length (i_message_length),
        .i_function_index (i_function_index),
        .i_function_type  (i_function_type),
        .i_segment_class  (i_segment_class),
        .i_segmented      (i_segmented),
        .o_ready          (o_ready),
        .o_push           (w_push),
        .o_op             (w_in_op)
    );

    // Word queue
    bcms_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_in_op),
        .i_pop   (w_pop),
        .o_op    (w_q_op),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Frame packer
    bcms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_q_op),
        .i_op_valid    (!w_q_empty),
        .o_op_pop      (w_pop),
        .o_frame       (w_frame),
        .o_frame_valid (o_valid),
        .i_frame_ready (i_ready)
    );

    // Frame fields onto ports
    assign o_frame_length = w_frame.length;
    assign o_frame_byte0  = w_frame.bytes[0];
    assign o_frame_byte1  = w_frame.bytes[1];
    assign o_frame_byte2  = w_frame.bytes[2];
    assign o_frame_byte3  = w_frame.bytes[3];
    assign o_frame_byte4  = w_frame.bytes[4];
    assign o_frame_byte5  = w_frame.bytes[5];
    assign o_frame_byte6  = w_frame.bytes[6];
    assign o_frame_byte7  = w_frame.bytes[7];
    assign o_last_frame   = w_frame.last;

    // Frame length stays within one CAN frame
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_length != 4'd0) && (o_frame_length <= FRAME_FULL))
        else $error("frame length out of range");

    // Only the closing frame of a message may be short
    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_frame_length != FRAME_FULL)) |-> o_last_frame)
        else $error("short frame without last flag");

    // An accepted word is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !w_q_empty)
        else $error("accepted word lost from queue");

endmodule
